[rtl/scpm_pkg.sv]
// Shared types, constants and helper functions for the sparse challenge multiplier.
package scpm_pkg;

    localparam int POLY_DEGREE = 256;
    localparam int DEG_BITS    = 8;
    localparam int T0_BITS     = 13;
    localparam int T1_BITS     = 10;
    localparam int SIGN_OFFSET = 60;
    localparam int CHAL_BYTES  = 68;
    localparam int T0_LEN      = POLY_DEGREE * T0_BITS / 8;
    localparam int T1_LEN      = POLY_DEGREE * T1_BITS / 8;
    localparam int BUF_BITS    = 20;
    localparam int FILL_BITS   = 5;
    localparam int CCNT_BITS   = 7;
    localparam int PCNT_BITS   = 9;
    localparam int USED_BITS   = 12;
    localparam int TERM_BITS   = 24;
    localparam int ACC_BITS    = 30;
    localparam int T0_CENTER   = 4096;

    // Reciprocals scaled by 2^16, exact for every bit count below 4096
    localparam logic [12:0] RECIP_T0 = 13'd5042;
    localparam logic [12:0] RECIP_T1 = 13'd6554;

    typedef enum logic [1:0] {
        MODE_CHAL = 2'd0,
        MODE_POLY = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    // Per-cell control: rotate the ring, or load a position or a sign bit
    typedef struct packed {
        logic                shift;
        logic                pos_we;
        logic [DEG_BITS-1:0] pos_data;
        logic                sign_we;
        logic                sign_data;
    } cell_ctl_t;

    // Field index = bits consumed / field width, modulo the degree
    function automatic logic [DEG_BITS-1:0] field_index(
        input logic [USED_BITS-1:0] used,
        input logic                 kind
    );
        logic [24:0] prod;
        prod = 25'(used) * 25'(kind ? RECIP_T1 : RECIP_T0);
        return prod[16 +: DEG_BITS];
    endfunction

    // Signed coefficient of a stored raw field, read at the current kind
    function automatic logic signed [TERM_BITS-1:0] coeff_of(
        input logic [T0_BITS-1:0] raw,
        input logic               kind
    );
        logic signed [TERM_BITS-1:0] c;
        if (kind)
            c = {1'b0, raw[T1_BITS-1:0], {T0_BITS{1'b0}}};
        else
            c = TERM_BITS'(T0_CENTER) - {{(TERM_BITS-T0_BITS){1'b0}}, raw};
        return c;
    endfunction

endpackage

[rtl/sparse_challenge_poly_multiply.sv]
// Sparse ternary challenge times packed polynomial modulo x^256+1, one coefficient per read.
//
// Challenge and polynomial bytes are taken one per cycle while the block is idle
// (in_stall is high otherwise); a polynomial byte also needs a drain step only
// when a kind change leaves two whole fields in the bit buffer. During a read
// item the ring of CHALLENGE_WEIGHT cells rotates once, handing one position a
// cycle to the single read port of the 256-entry field memory, and a three-stage
// fetch/scale/accumulate pipeline drains after the last term. Field memory
// entries carry valid bits cleared at reset, so no clearing pass is needed.
// The result sits in an output register, so loads and the next read proceed
// while a result waits.
module sparse_challenge_poly_multiply #(
    parameter int CHALLENGE_WEIGHT = 39
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           mode,
    input  logic [7:0]                           data_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [scpm_pkg::ACC_BITS-1:0] product_coeff,
    output logic [scpm_pkg::DEG_BITS-1:0]        coeff_index,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data
);
    import scpm_pkg::*;

    localparam int CNT_W = (CHALLENGE_WEIGHT > 1) ? $clog2(CHALLENGE_WEIGHT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_READ,
        ST_FLUSH
    } state_t;

    state_t                      state_reg;
    logic                        kind_reg;
    logic [CCNT_BITS-1:0]        ccnt_reg;
    logic [PCNT_BITS-1:0]        pcnt_reg;
    logic [BUF_BITS-1:0]         buf_reg;
    logic [FILL_BITS-1:0]        fill_reg;
    logic [DEG_BITS-1:0]         rd_idx_reg;
    logic [CNT_W-1:0]            term_cnt_reg;
    logic                        neg_s1_reg;
    logic                        vld_s1_reg;
    logic signed [TERM_BITS-1:0] term_reg;
    logic                        vld_s2_reg;
    logic [ACC_BITS-1:0]         acc_reg;
    logic                        out_valid_reg;
    logic [ACC_BITS-1:0]         out_coeff_reg;
    logic [DEG_BITS-1:0]         out_idx_reg;
    logic                        out_last_reg;

    logic accept;
    logic out_load;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------- challenge ring ----------------
    logic [DEG_BITS-1:0] ring_pos  [CHALLENGE_WEIGHT];
    logic                ring_sign [CHALLENGE_WEIGHT];

    for (genvar k = 0; k < CHALLENGE_WEIGHT; k++)
    begin : g_cell
        localparam int SIGN_BYTE = SIGN_OFFSET + k / 8;
        localparam int SIGN_BIT  = k % 8;
        localparam int NEXT      = (k + 1) % CHALLENGE_WEIGHT;
        cell_ctl_t ctl;
        always_comb
        begin
            ctl.shift     = (state_reg == ST_READ);
            ctl.pos_we    = accept && (mode_t'(mode) == MODE_CHAL)
                            && (ccnt_reg == CCNT_BITS'(k));
            ctl.pos_data  = data_byte;
            ctl.sign_we   = accept && (mode_t'(mode) == MODE_CHAL)
                            && (ccnt_reg == CCNT_BITS'(SIGN_BYTE));
            ctl.sign_data = data_byte[SIGN_BIT];
        end
        scpm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .pos_in   (ring_pos[NEXT]),
            .sign_in  (ring_sign[NEXT]),
            .pos_out  (ring_pos[k]),
            .sign_out (ring_sign[k])
        );
    end

    // ---------------- packed stream unpacking ----------------
    logic [FILL_BITS-1:0] fw;
    logic [PCNT_BITS-1:0] plen;
    logic [BUF_BITS-1:0]  src_buf;
    logic [FILL_BITS-1:0] src_fill;
    logic [PCNT_BITS-1:0] src_cnt;
    logic [USED_BITS-1:0] total;
    logic [USED_BITS-1:0] used;
    logic                 split;
    logic [BUF_BITS-1:0]  buf_split;
    logic [FILL_BITS-1:0] fill_split;
    logic                 mem_we;
    logic [DEG_BITS-1:0]  mem_waddr;
    logic [T0_BITS-1:0]   mem_wdata;
    logic                 poly_accept;

    assign poly_accept = accept && (mode_t'(mode) == MODE_POLY);
    assign fw   = kind_reg ? FILL_BITS'(T1_BITS) : FILL_BITS'(T0_BITS);
    assign plen = kind_reg ? PCNT_BITS'(T1_LEN) : PCNT_BITS'(T0_LEN);

    always_comb
    begin
        // Drain works on the held buffer; otherwise append the incoming byte
        if (state_reg == ST_DRAIN)
        begin
            src_buf  = buf_reg;
            src_fill = fill_reg;
            src_cnt  = pcnt_reg;
        end
        else
        begin
            src_buf  = buf_reg | (BUF_BITS'(data_byte) << fill_reg);
            src_fill = fill_reg + FILL_BITS'(8);
            src_cnt  = pcnt_reg + PCNT_BITS'(1);
        end
        total = {src_cnt, 3'b000};
        used  = (total >= USED_BITS'(src_fill)) ? total - USED_BITS'(src_fill) : '0;
        split = (src_fill >= fw);
        buf_split  = split ? (src_buf >> fw) : src_buf;
        fill_split = split ? (src_fill - fw) : src_fill;
        mem_we     = split && (poly_accept || (state_reg == ST_DRAIN));
        mem_waddr  = field_index(used, kind_reg);
        mem_wdata  = kind_reg ? {{(T0_BITS-T1_BITS){1'b0}}, src_buf[T1_BITS-1:0]}
                              : src_buf[T0_BITS-1:0];
    end

    // ---------------- field memory and term pipeline ----------------
    logic [DEG_BITS-1:0] rd_addr;
    logic                rd_wrap;
    logic [T0_BITS-1:0]  rd_data;
    logic signed [TERM_BITS-1:0] coeff;

    assign rd_addr = rd_idx_reg - ring_pos[0];
    assign rd_wrap = (rd_idx_reg < ring_pos[0]);
    assign coeff   = coeff_of(rd_data, kind_reg);

    scpm_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (state_reg == ST_READ),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        term_reg <= neg_s1_reg ? -coeff : coeff;
        neg_s1_reg <= rd_wrap ^ ring_sign[0];
    end

    assign out_load = (state_reg == ST_FLUSH) && !vld_s1_reg && !vld_s2_reg
                      && (!out_valid_reg || !out_stall);

    // ---------------- control, counters and output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= 1'b0;
            ccnt_reg      <= '0;
            pcnt_reg      <= '0;
            buf_reg       <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            term_cnt_reg  <= '0;
            vld_s1_reg    <= 1'b0;
            vld_s2_reg    <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kind_reg <= cfg_data;

            vld_s1_reg <= (state_reg == ST_READ);
            vld_s2_reg <= vld_s1_reg;
            if (vld_s2_reg)
                acc_reg <= acc_reg + ACC_BITS'(term_reg);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (mode_t'(mode))
                            MODE_CHAL:
                                ccnt_reg <= (ccnt_reg >= CCNT_BITS'(CHAL_BYTES - 1))
                                            ? '0 : ccnt_reg + CCNT_BITS'(1);
                            MODE_POLY:
                            begin
                                // A second whole field waits: split it next cycle
                                if (fill_split >= fw)
                                begin
                                    buf_reg   <= buf_split;
                                    fill_reg  <= fill_split;
                                    pcnt_reg  <= src_cnt;
                                    state_reg <= ST_DRAIN;
                                end
                                else if (src_cnt >= plen)
                                begin
                                    buf_reg  <= '0;
                                    fill_reg <= '0;
                                    pcnt_reg <= '0;
                                end
                                else
                                begin
                                    buf_reg  <= buf_split;
                                    fill_reg <= fill_split;
                                    pcnt_reg <= src_cnt;
                                end
                            end
                            MODE_READ:
                            begin
                                acc_reg      <= '0;
                                term_cnt_reg <= '0;
                                state_reg    <= ST_READ;
                            end
                            MODE_NOP:
                            begin
                            end
                        endcase
                    end
                end
                ST_DRAIN:
                begin
                    if (pcnt_reg >= plen)
                    begin
                        buf_reg  <= '0;
                        fill_reg <= '0;
                        pcnt_reg <= '0;
                    end
                    else
                    begin
                        buf_reg  <= buf_split;
                        fill_reg <= fill_split;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_READ:
                begin
                    term_cnt_reg <= term_cnt_reg + CNT_W'(1);
                    if (term_cnt_reg == CNT_W'(CHALLENGE_WEIGHT - 1))
                        state_reg <= ST_FLUSH;
                end
                ST_FLUSH:
                begin
                    if (out_load)
                    begin
                        rd_idx_reg <= rd_idx_reg + DEG_BITS'(1);
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_coeff_reg <= acc_reg;
            out_idx_reg   <= rd_idx_reg;
            out_last_reg  <= (rd_idx_reg == DEG_BITS'(POLY_DEGREE - 1));
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_coeff = out_coeff_reg;
    assign coeff_index   = out_idx_reg;
    assign last          = out_last_reg;

`ifndef SYNTHESIS
    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !mem_we)
        else $error("field memory written during a read");

    a_idle_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < FILL_BITS'(T0_BITS)))
        else $error("bit buffer holds a whole field while idle");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!vld_s1_reg && !vld_s2_reg))
        else $error("term pipeline busy while idle");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (coeff_index == $past(rd_idx_reg)))
        else $error("returned index does not match read index");
`endif

endmodule

[rtl/scpm_cell.sv]
// One cell of the challenge ring: a position and its sign, rotated during reads.
module scpm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scpm_pkg::cell_ctl_t           ctl,
    input  logic [scpm_pkg::DEG_BITS-1:0] pos_in,
    input  logic                          sign_in,
    output logic [scpm_pkg::DEG_BITS-1:0] pos_out,
    output logic                          sign_out
);
    import scpm_pkg::*;

    logic [DEG_BITS-1:0] pos_reg;
    logic                sign_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sign_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            pos_reg  <= pos_in;
            sign_reg <= sign_in;
        end
        else
        begin
            if (ctl.pos_we)
                pos_reg <= ctl.pos_data;
            if (ctl.sign_we)
                sign_reg <= ctl.sign_data;
        end
    end

    assign pos_out  = pos_reg;
    assign sign_out = sign_reg;

endmodule

[rtl/scpm_store.sv]
// Polynomial field memory with per-entry valid bits; unwritten entries read as zero.
module scpm_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [scpm_pkg::DEG_BITS-1:0] waddr,
    input  logic [scpm_pkg::T0_BITS-1:0]  wdata,
    input  logic                          re,
    input  logic [scpm_pkg::DEG_BITS-1:0] raddr,
    output logic [scpm_pkg::T0_BITS-1:0]  rdata
);
    import scpm_pkg::*;

    logic [T0_BITS-1:0]     mem [POLY_DEGREE];
    logic [POLY_DEGREE-1:0] valid_reg;
    logic [T0_BITS-1:0]     data_reg;
    logic                   hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            if (re)
                hit_reg <= valid_reg[raddr];
        end
    end

    assign rdata = hit_reg ? data_reg : '0;

endmodule

[tb/scpm_product_checker.sv]
// Checker for the sparse challenge multiplier: predicts each product coefficient and compares.
module scpm_product_checker #(
    parameter int CHALLENGE_WEIGHT = 39
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [1:0]                           mode,
    input  logic [7:0]                           data_byte,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [scpm_pkg::ACC_BITS-1:0] product_coeff,
    input  logic [scpm_pkg::DEG_BITS-1:0]        coeff_index,
    input  logic                                 last,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic                                 cfg_data,
    output int                                   mismatch_count,
    output int                                   products_outstanding
);
    import scpm_pkg::*;

    typedef struct packed {
        logic [ACC_BITS-1:0] coeff;
        logic [DEG_BITS-1:0] idx;
        logic                is_last;
    } product_t;

    logic [DEG_BITS-1:0] positions [CHALLENGE_WEIGHT];
    logic [63:0]         signs;
    logic [T0_BITS-1:0]  fields [POLY_DEGREE];
    int unsigned         chal_count;
    int unsigned         poly_count;
    logic [31:0]         bit_buf;
    int unsigned         bit_fill;
    logic [DEG_BITS-1:0] read_ptr;
    logic                kind;
    int                  fails;
    product_t            expected_products [$];

    // Stored raw field seen at the current kind
    function automatic longint coeff_value(input logic [T0_BITS-1:0] raw);
        if (kind)
            return longint'(raw[T1_BITS-1:0]) << T0_BITS;
        return longint'(T0_CENTER) - longint'(raw);
    endfunction

    // Product coefficient i: signed sum over the challenge positions, negated on wrap
    function automatic longint negacyclic_sum(input logic [DEG_BITS-1:0] i);
        longint      sum;
        longint      term;
        int unsigned n;
        int unsigned p;
        int          k;
        sum = 0;
        n = i;
        for (k = 0; k < CHALLENGE_WEIGHT; k++)
        begin
            p = positions[k];
            if (n >= p)
                term = coeff_value(fields[n - p]);
            else
                term = -coeff_value(fields[n + POLY_DEGREE - p]);
            if (signs[k])
                term = -term;
            sum += term;
        end
        return sum;
    endfunction

    task automatic take_challenge_byte(input logic [7:0] b);
        if (chal_count < CHALLENGE_WEIGHT)
            positions[chal_count] = b;
        if (chal_count >= SIGN_OFFSET && chal_count < CHAL_BYTES)
            signs[8 * (chal_count - SIGN_OFFSET) +: 8] = b;
        chal_count = (chal_count + 1 >= CHAL_BYTES) ? 0 : chal_count + 1;
    endtask

    task automatic take_poly_byte(input logic [7:0] b);
        int unsigned w;
        int unsigned len;
        int unsigned total;
        int unsigned used;
        w = kind ? T1_BITS : T0_BITS;
        len = POLY_DEGREE * w / 8;
        bit_buf = bit_buf | (32'(b) << bit_fill);
        bit_fill += 8;
        poly_count++;
        // Split off every whole field; the index follows the bits consumed so far
        while (bit_fill >= w)
        begin
            total = poly_count * 8;
            used = (total >= bit_fill) ? total - bit_fill : 0;
            fields[(used / w) % POLY_DEGREE] = T0_BITS'(bit_buf & ((32'd1 << w) - 32'd1));
            bit_buf = bit_buf >> w;
            bit_fill -= w;
        end
        bit_buf &= 32'hFFFFF;
        if (poly_count >= len)
        begin
            poly_count = 0;
            bit_buf = '0;
            bit_fill = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int k;
            for (k = 0; k < CHALLENGE_WEIGHT; k++)
                positions[k] = '0;
            for (k = 0; k < POLY_DEGREE; k++)
                fields[k] = '0;
            signs = '0;
            chal_count = 0;
            poly_count = 0;
            bit_buf = '0;
            bit_fill = 0;
            read_ptr = '0;
            kind = 1'b0;
            fails = 0;
            expected_products.delete();
            mismatch_count <= 0;
            products_outstanding <= 0;
        end
        else
        begin
            longint   sum;
            product_t head;
            if (cfg_valid && cfg_ready)
                kind = cfg_data;
            if (in_valid && !in_stall)
            begin
                case (mode)
                    MODE_CHAL: take_challenge_byte(data_byte);
                    MODE_POLY: take_poly_byte(data_byte);
                    MODE_READ:
                    begin
                        sum = negacyclic_sum(read_ptr);
                        head.coeff = sum[ACC_BITS-1:0];
                        head.idx = read_ptr;
                        head.is_last = (read_ptr == DEG_BITS'(POLY_DEGREE - 1));
                        expected_products.push_back(head);
                        read_ptr = read_ptr + 1'b1;
                    end
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_products.size() == 0)
                begin
                    $error("product_coeff: no result expected, actual %0d at coeff_index %0d",
                           product_coeff, coeff_index);
                    fails++;
                end
                else
                begin
                    head = expected_products.pop_front();
                    if (product_coeff !== head.coeff)
                    begin
                        $error("product_coeff: expected %0d, actual %0d",
                               $signed(head.coeff), product_coeff);
                        fails++;
                    end
                    if (coeff_index !== head.idx)
                    begin
                        $error("coeff_index: expected %0d, actual %0d", head.idx, coeff_index);
                        fails++;
                    end
                    if (last !== head.is_last)
                    begin
                        $error("last: expected %0d, actual %0d", head.is_last, last);
                        fails++;
                    end
                end
            end
            mismatch_count <= fails;
            products_outstanding <= expected_products.size();
        end
    end

endmodule

[tb/sparse_challenge_poly_multiply_tb.sv]
// Testbench top for the sparse challenge multiplier: stimulus, stalls, config and verdict.
module sparse_challenge_poly_multiply_tb;
    import scpm_pkg::*;

    localparam int          CHALLENGE_WEIGHT = 39;
    localparam int          SEGMENTS         = 6;
    localparam int          SEGMENT_ITEMS    = 325;
    localparam int          SETTLE_CYCLES    = CHALLENGE_WEIGHT + 12;
    localparam longint      TIMEOUT_CYCLES   = 1_000_000;
    // Kind per segment, segment 0 in bit 0
    localparam logic [5:0]  SEGMENT_KIND     = 6'b011001;

    localparam int unsigned FILL_RANDOM = 0;
    localparam int unsigned FILL_ONES   = 1;
    localparam int unsigned FILL_ZEROS  = 2;
    localparam int unsigned FILL_FIXED  = 3;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 mode = 2'd0;
    logic [7:0]                 data_byte = 8'd0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [ACC_BITS-1:0] product_coeff;
    logic [DEG_BITS-1:0]        coeff_index;
    logic                       last;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_data = 1'b0;
    int                         mismatch_count;
    int                         products_outstanding;

    int unsigned send_idle_pct = 31;
    int unsigned recv_idle_pct = 88;
    int unsigned item_count = 0;
    int unsigned chal_fill = 0;
    int unsigned poly_fill = 0;
    logic        cur_kind = 1'b0;

    sparse_challenge_poly_multiply #(
        .CHALLENGE_WEIGHT(CHALLENGE_WEIGHT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .product_coeff(product_coeff),
        .coeff_index(coeff_index),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    scpm_product_checker #(
        .CHALLENGE_WEIGHT(CHALLENGE_WEIGHT)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .product_coeff(product_coeff),
        .coeff_index(coeff_index),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count),
        .products_outstanding(products_outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    function automatic int unsigned poly_len();
        return cur_kind ? T1_LEN : T0_LEN;
    endfunction

    function automatic logic [7:0] fill_byte(input int unsigned style, input logic [7:0] value);
        case (style)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            FILL_FIXED: return value;
            default:    return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input mode_t m, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        item_count++;
        // Track the load counters so records can be completed in step with the block
        if (m == MODE_CHAL)
            chal_fill = (chal_fill + 1) % CHAL_BYTES;
        if (m == MODE_POLY)
        begin
            poly_fill++;
            if (poly_fill >= poly_len())
                poly_fill = 0;
        end
    endtask

    // Complete the current challenge record
    task automatic send_challenge(input int unsigned pos_style, input logic [7:0] pos_value,
                                  input int unsigned sign_style);
        logic [7:0] b;
        do
        begin
            if (chal_fill >= SIGN_OFFSET)
                b = fill_byte(sign_style, 8'h00);
            else
                b = fill_byte(pos_style, pos_value);
            send_item(MODE_CHAL, b);
        end
        while (chal_fill != 0);
    endtask

    task automatic send_poly(input int unsigned count, input int unsigned style);
        repeat (count)
            send_item(MODE_POLY, fill_byte(style, 8'h00));
    endtask

    task automatic send_reads(input int unsigned count);
        repeat (count)
            send_item(MODE_READ, 8'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (products_outstanding != 0)
            @(posedge clk);
        // Let trailing loads settle before touching the register
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_kind(input logic k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_kind = k;
    endtask

    initial
    begin
        int          seg;
        int unsigned pick;
        rst_n = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: read of the cleared state, idle mode, extreme bytes
        send_item(MODE_READ, 8'h00);
        send_item(MODE_NOP, 8'hFF);
        send_item(MODE_NOP, 8'h00);
        send_item(MODE_CHAL, 8'hFF);
        send_item(MODE_CHAL, 8'h00);
        send_item(MODE_CHAL, 8'h80);
        send_item(MODE_CHAL, 8'h7F);
        send_item(MODE_POLY, 8'hFF);
        send_item(MODE_POLY, 8'h00);
        send_item(MODE_POLY, 8'hFF);
        send_item(MODE_POLY, 8'h55);
        send_reads(3);
        send_item(MODE_READ, 8'hFF);
        send_item(MODE_NOP, 8'hA5);
        send_item(MODE_READ, 8'h5A);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 31;
            end
            if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            write_kind(SEGMENT_KIND[seg]);
            item_count = 0;
            if (seg == 0 || seg == 3)
            begin
                // All-ones polynomial and a single repeated position: largest magnitudes
                send_poly(poly_len() + 8, FILL_ONES);
                send_challenge(FILL_FIXED, (seg == 0) ? 8'd0 : 8'd255, FILL_ZEROS);
                send_reads(16);
            end
            while (item_count < SEGMENT_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                    send_challenge($urandom_range(1) ? FILL_FIXED : FILL_RANDOM,
                                   8'($urandom), $urandom_range(2));
                else if (pick < 45)
                begin
                    pick = $urandom_range(9);
                    send_poly($urandom_range(64, 8), (pick == 0) ? FILL_ONES :
                              (pick == 1) ? FILL_ZEROS : FILL_RANDOM);
                end
                else if (pick < 80)
                    send_reads($urandom_range(48, 1));
                else if (pick < 90)
                    repeat ($urandom_range(6, 1))
                        send_item(mode_t'($urandom_range(3)), 8'($urandom));
                else
                    // Broken record: leave the challenge counter mid-way
                    repeat ($urandom_range(20, 1))
                        send_item(MODE_CHAL, 8'($urandom));
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 20);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
